>>> rtl/dur_pkg.sv
// Package for the decayed usage residency policy block.
// Holds shared constants, the sequencer state type and the config register indexes.
package dur_pkg;
  localparam int unsigned ScoreW = 32;
  localparam logic [31:0] ScoreMax = 32'hFFFF_FFFF;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [16:0] DecayOne = 17'h10000;
  localparam logic [15:0] HystOne = 16'd256;
  localparam logic [6:0] BudgetRst = 7'd16;
  localparam logic [5:0] MaxSwaps = 6'd32;

  localparam logic [1:0] RegBudget = 2'd0;
  localparam logic [1:0] RegDecay = 2'd1;
  localparam logic [1:0] RegHyst = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StDecayRd,
    StDecayWr,
    StCount,
    StCountWr,
    StScan,
    StScanLast,
    StMul,
    StCmp,
    StSwap,
    StOut
  } state_e;
endpackage

>>> rtl/dur_mac.sv
// Shared arithmetic unit: registered multiply of a 32-bit score by a 17-bit factor.
// Depends on dur_pkg.
module dur_mac (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [16:0] b_i,
  output logic [48:0] p_o
);
  import dur_pkg::*;
  logic [48:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= {17'd0, a_i} * {32'd0, b_i};
  end
  assign p_o = p_q;
endmodule

>>> rtl/decayed_usage_residency_policy_top.sv
// Decayed usage residency policy: LFU with aging and hysteresis over NUM_ENTRIES entries.
// An ordinary item updates its count; batch_start first decays every score through the
// shared multiplier when the decay factor is below one; batch_end adds, per result, a scan
// of the score memory and the hysteresis multiply, plus an output state per result.
// Reset and every write to a known config register run a clearing pass over the
// scores before s_axis_tready rises.
module decayed_usage_residency_policy_top #(
  parameter int unsigned NUM_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // expert_id
  input  logic [2:0]  s_axis_tuser,   // id_present, batch_start, batch_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // evicted_id[5:0], admitted_id[11:6], swap_valid[12]
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import dur_pkg::*;
  localparam int unsigned IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam logic [IdxW:0] NumE = (IdxW + 1)'(NUM_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ENTRIES - 1);

  state_e state_q, state_d;
  logic [31:0] mem [NUM_ENTRIES];
  logic [31:0] rd_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic wr_en;
  logic [NUM_ENTRIES-1:0] res_q, res_d;
  logic [6:0] budget_q;
  logic [16:0] decay_q;
  logic [15:0] hyst_q;
  logic [IdxW-1:0] cnt_q, cnt_d, rcnt_q, rcnt_d;
  logic [7:0] id_q, id_d;
  logic pres_q, pres_d, end_q, end_d;
  logic [5:0] swaps_q, swaps_d;
  logic hv_q, hv_d, hc_q, hc_d;
  logic [IdxW-1:0] v_q, v_d, c_q, c_d;
  logic [31:0] vs_q, vs_d, cs_q, cs_d;
  logic [48:0] prod;
  logic [31:0] mac_a;
  logic [16:0] mac_b;
  logic [15:0] od_q, od_d;
  logic ol_q, ol_d;
  logic [IdxW:0] blim;

  dur_mac u_mac (.clk_i, .a_i(mac_a), .b_i(mac_b), .p_o(prod));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign blim = ({1'b0, budget_q} > 8'(NumE)) ? NumE : (IdxW + 1)'(budget_q);
  assign cfg_ready_o = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = od_q;
  assign m_axis_tlast = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BudgetRst;
      decay_q <= DecayOne;
      hyst_q <= HystOne;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBudget: budget_q <= cfg_data_i[6:0];
        RegDecay:  decay_q <= cfg_data_i;
        RegHyst:   hyst_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q <= '0;
      rcnt_q <= '0;
      res_q <= '0;
      swaps_q <= '0;
      hv_q <= 1'b0;
      hc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rcnt_q <= rcnt_d;
      res_q <= res_d;
      swaps_q <= swaps_d;
      hv_q <= hv_d;
      hc_q <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; pres_q <= pres_d; end_q <= end_d;
    v_q <= v_d; c_q <= c_d; vs_q <= vs_d; cs_q <= cs_d;
    od_q <= od_d; ol_q <= ol_d;
  end

  always_comb begin
    logic [IdxW:0] e;
    logic [15:0] h;
    e = '0;
    state_d = state_q; cnt_d = cnt_q; rcnt_d = rcnt_q; res_d = res_q;
    swaps_d = swaps_q; hv_d = hv_q; hc_d = hc_q;
    id_d = id_q; pres_d = pres_q; end_d = end_q;
    v_d = v_q; c_d = c_q; vs_d = vs_q; cs_d = cs_q;
    od_d = od_q; ol_d = ol_q;
    rd_addr = cnt_q; wr_addr = cnt_q; wr_data = '0; wr_en = 1'b0;
    mac_a = rd_q; mac_b = decay_q;
    h = (hyst_q < HystOne) ? HystOne : hyst_q;
    case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          // unknown register index: accept and drop the write
          if (cfg_index_i inside {RegBudget, RegDecay, RegHyst}) begin
            state_d = StClear; cnt_d = '0;
          end
        end else if (s_axis_tvalid) begin
          id_d = s_axis_tdata; pres_d = s_axis_tuser[0]; end_d = s_axis_tuser[2];
          swaps_d = '0; cnt_d = '0; rcnt_d = '0;
          if (s_axis_tuser[1] && decay_q < DecayOne) state_d = StDecayRd;
          else state_d = StCount;
        end
      end
      StClear: begin
        wr_en = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++) res_d[i] = ((IdxW + 1)'(i) < blim);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d = '0; state_d = StIdle;
        end
      end
      StDecayRd: begin
        state_d = StDecayWr;
      end
      StDecayWr: begin
        // rd_q valid now; product next cycle written via wait step merged here
        mac_a = rd_q;
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q[0]) begin
          wr_en = 1'b1; wr_data = prod[47:16];
          rcnt_d = '0;
          cnt_d = cnt_q + 1'b1;
          state_d = (cnt_q == LastIdx) ? StCount : StDecayRd;
          if (cnt_q == LastIdx) cnt_d = '0;
        end
      end
      StCount: begin
        rd_addr = id_q[IdxW-1:0];
        if (pres_q && {1'b0, id_q} < 9'(NumE)) state_d = StCountWr;
        else if (end_q) begin
          state_d = StScan; cnt_d = '0; hv_d = 1'b0; hc_d = 1'b0;
        end else state_d = StIdle;
      end
      StCountWr: begin
        rd_addr = id_q[IdxW-1:0];
        wr_addr = id_q[IdxW-1:0];
        wr_en = 1'b1;
        wr_data = (rd_q > ScoreMax - OneQ16) ? ScoreMax : rd_q + OneQ16;
        pres_d = 1'b0;
        state_d = StCount;
      end
      StScan: begin
        // read entry cnt, compare entry cnt-1 (registered data)
        rd_addr = cnt_q;
        if (rcnt_q != 0) begin
          e = {1'b0, cnt_q} - 1'b1;
          if (res_q[e[IdxW-1:0]]) begin
            if (!hv_q || rd_q < vs_q) begin hv_d = 1'b1; v_d = e[IdxW-1:0]; vs_d = rd_q; end
          end else if (!hc_q || rd_q > cs_q) begin
            hc_d = 1'b1; c_d = e[IdxW-1:0]; cs_d = rd_q;
          end
        end
        rcnt_d = 1'b1;
        if (cnt_q == LastIdx) state_d = StScanLast;
        else cnt_d = cnt_q + 1'b1;
      end
      StScanLast: begin
        if (res_q[LastIdx]) begin
          if (!hv_q || rd_q < vs_q) begin hv_d = 1'b1; v_d = LastIdx; vs_d = rd_q; end
        end else if (!hc_q || rd_q > cs_q) begin
          hc_d = 1'b1; c_d = LastIdx; cs_d = rd_q;
        end
        state_d = StMul;
      end
      StMul: begin
        // victim score times hysteresis through the shared multiplier
        mac_a = vs_q;
        mac_b = {1'b0, h};
        state_d = StCmp;
      end
      StCmp: begin
        if (hv_q && hc_q && {9'd0, cs_q, 8'd0} > prod && swaps_q < MaxSwaps) begin
          res_d[v_q] = 1'b0; res_d[c_q] = 1'b1;
          od_d = {3'd0, 1'b1, 6'(c_q), 6'(v_q)}; ol_d = 1'b0;
          swaps_d = swaps_q + 1'b1;
        end else begin
          od_d = '0; ol_d = 1'b1;
        end
        state_d = StOut;
      end
      StOut: begin
        if (m_axis_tready) begin
          if (ol_q) state_d = StIdle;
          else begin
            state_d = StScan; cnt_d = '0; rcnt_d = '0; hv_d = 1'b0; hc_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken while result pending");
  a_swap_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swaps_q <= MaxSwaps) else $error("swap count above cap");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

>>> bench/decayed_usage_residency_policy_top_tb.sv
// Self-checking bench for decayed_usage_residency_policy_top: score batches, check swap reports.
// Depends on dur_pkg for register indexes and constants; the scoreboard keeps its own scores.
module decayed_usage_residency_policy_top_tb;
  import dur_pkg::*;

  localparam int unsigned Entries = 64;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 400;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [5:0] evicted;
    logic [5:0] admitted;
    logic       swap;
    logic       last;
  } swap_rec_t;

  class residency_scoreboard;
    bit [31:0] score[Entries];
    bit        resident[Entries];
    bit [6:0]  budget;
    bit [16:0] decay;
    bit [15:0] hyst;
    swap_rec_t swaps_q[$];
    int        errors;

    function new();
      budget = BudgetRst;
      decay  = DecayOne;
      hyst   = HystOne;
      errors = 0;
      reseed();
    endfunction

    function void reseed();
      int unsigned b;
      b = (budget > Entries) ? Entries : budget;
      for (int e = 0; e < Entries; e++) begin
        score[e]    = '0;
        resident[e] = (e < b);
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        RegBudget: budget = val[6:0];
        RegDecay:  decay  = val;
        RegHyst:   hyst   = val[15:0];
        default:   return;
      endcase
      reseed();
    endfunction

    // Accepted input: apply decay and count, then at batch end plan the residency swaps.
    function void note_item(bit [7:0] id, bit present, bit start, bit fin);
      longint unsigned d, h, vs, cs;
      int              v, c, n;
      bit              have_v, have_c;
      swap_rec_t       rec;
      if (start) begin
        d = (decay > DecayOne) ? DecayOne : decay;
        if (d != DecayOne)
          for (int e = 0; e < Entries; e++) score[e] = 32'((longint'(score[e]) * d) >> 16);
      end
      if (present && id < Entries)
        score[id] = (score[id] > ScoreMax - OneQ16) ? ScoreMax : score[id] + OneQ16;
      if (!fin) return;
      h = (hyst < HystOne) ? HystOne : hyst;
      n = 0;
      while (n < MaxSwaps) begin
        have_v = 0; have_c = 0; v = 0; c = 0; vs = 0; cs = 0;
        for (int e = 0; e < Entries; e++) begin
          if (resident[e]) begin
            if (!have_v || score[e] < vs) begin have_v = 1; v = e; vs = score[e]; end
          end else begin
            if (!have_c || score[e] > cs) begin have_c = 1; c = e; cs = score[e]; end
          end
        end
        if (!have_v || !have_c || !(cs * 256 > vs * h)) break;
        resident[v] = 0;
        resident[c] = 1;
        rec = '{evicted: 6'(v), admitted: 6'(c), swap: 1'b1, last: 1'b0};
        swaps_q = {swaps_q, rec};
        n++;
      end
      rec = '{evicted: 6'd0, admitted: 6'd0, swap: 1'b0, last: 1'b1};
      swaps_q = {swaps_q, rec};
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(swap_rec_t got);
      swap_rec_t want;
      if (swaps_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = swaps_q.pop_front();
      if (got.evicted != want.evicted)
        report($sformatf("evicted_id %0d, want %0d", got.evicted, want.evicted));
      if (got.admitted != want.admitted)
        report($sformatf("admitted_id %0d, want %0d", got.admitted, want.admitted));
      if (got.swap != want.swap)
        report($sformatf("swap_valid %0d, want %0d", got.swap, want.swap));
      if (got.last != want.last)
        report($sformatf("last_result %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // expert_id
  logic [2:0]  s_axis_tuser = '0;   // id_present, batch_start, batch_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // evicted_id, admitted_id, swap_valid
  logic        m_axis_tlast;        // last_result
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  residency_scoreboard sb = new();
  bit          quiet = 1'b0;
  int unsigned cycles = 0;

  decayed_usage_residency_policy_top #(.NUM_ENTRIES(Entries)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{evicted: m_axis_tdata[5:0], admitted: m_axis_tdata[11:6],
                        swap: m_axis_tdata[12], last: m_axis_tlast});
    m_axis_tready <= quiet || ($urandom_range(99) >= 7);
  end

  task automatic send_item(logic [7:0] id, logic present, logic start, logic fin);
    if (!quiet)
      while ($urandom_range(99) < 7) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= {fin, start, present};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(id, present, start, fin);
  endtask

  // Hold off until every result is in, then let a trailing decay or count finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.swaps_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed batch around a hot set so that swaps happen; some ids stray.
  task automatic run_batch(int len);
    logic [7:0] id;
    logic       present;
    int         base;
    base = $urandom_range(0, Entries - 8);
    for (int k = 0; k < len; k++) begin
      present = ($urandom_range(99) >= 8);
      case ($urandom_range(9))
        0:       id = 8'($urandom_range(64, 255));
        1, 2:    id = 8'($urandom_range(0, Entries - 1));
        default: id = 8'($urandom_range(base, base + 7));
      endcase
      send_item(id, present, k == 0, k == len - 1);
    end
  endtask

  initial begin
    logic [6:0]  budgets[5];
    logic [16:0] decays[5];
    logic [15:0] hysts[5];
    int          sent;
    int          len;

    budgets = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd40};
    decays  = '{17'd0, 17'd100000, 17'd32768, 17'd65535, 17'h10000};
    hysts   = '{16'd0, 16'd65535, 16'd256, 16'd384, 16'd300};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default settings after reset.
    send_item(8'd20, 1'b1, 1'b1, 1'b1);   // one hit on a non-resident swaps it in
    send_item(8'd255, 1'b1, 1'b1, 1'b0);  // out of range id
    send_item(8'd5, 1'b0, 1'b0, 1'b0);    // id not present
    send_item(8'd63, 1'b1, 1'b0, 1'b0);
    send_item(8'd63, 1'b1, 1'b0, 1'b1);
    send_item(8'd0, 1'b0, 1'b1, 1'b1);    // empty batch marker
    send_item(8'd64, 1'b1, 1'b0, 1'b1);
    send_item(8'd170, 1'b1, 1'b0, 1'b0);
    for (int k = 0; k < 8; k++) send_item(8'(32 + k), 1'b1, k == 0, 1'b0);
    send_item(8'd85, 1'b1, 1'b0, 1'b1);
    send_item(8'd42, 1'b1, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) write_cfg(RegUnused, 17'h1FFFF);
      write_cfg(RegBudget, 17'(budgets[ph]));
      write_cfg(RegDecay, decays[ph]);
      write_cfg(RegHyst, 17'(hysts[ph]));
      quiet = (ph == 2);
      sent = 0;
      while (sent < 21) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          run_batch(len);
          sent += len;
        end
        if (ph == 3 && sent > 12 && sent < 16) drain();
      end
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
